// ----- hdl/tlf_pkg.sv -----
// tlf_pkg: shared types and constants for the text line framer.
// No dependencies; imported by every module of the block.
package tlf_pkg;

  // Stream payload widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned M_TDATA_W  = 16;  // char_out, had_error, zero fill

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CAP_W      = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic REG_LINE_CAPACITY = 1'b0;  // register index, paddr[2]

  // Special characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE     = 2'd0,
    OP_TAKE_ERR = 2'd1,
    OP_OVERRUN  = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

endpackage

// ----- hdl/tlf_line_mem.sv -----
// tlf_line_mem: line store, one write port and one registered read port.
// Depends on tlf_pkg for the character width.
module tlf_line_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [$clog2(DEPTH)-1:0]           waddr_i,
  input  logic [tlf_pkg::BYTE_W-1:0]         wdata_i,
  input  logic                               re_i,
  input  logic [$clog2(DEPTH)-1:0]           raddr_i,
  output logic [tlf_pkg::BYTE_W-1:0]         rdata_o
);
  import tlf_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tlf_apb_regs.sv -----
// tlf_apb_regs: APB register file holding line_capacity.
// Depends on tlf_pkg for address, data and register widths.
module tlf_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tlf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tlf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [tlf_pkg::CAP_W-1:0]       cap_o
);
  import tlf_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             wr_en;
  logic             sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[2] == REG_LINE_CAPACITY);
  assign wr_en   = psel && penable && pwrite && pready && sel_cap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (wr_en) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = sel_cap ? {{(APB_DATA_W-CAP_W){1'b0}}, cap_q} : '0;
  assign cap_o  = cap_q;

endmodule

// ----- hdl/text_line_framer.sv -----
// text_line_framer: assembles received bytes into text lines.
// A byte, overrun or CR transfer gives no result; a take-error item or an empty
// line shows its result in the cycle after acceptance. A stored line goes out via
// the memory read and output registers, then 1 char a cycle unless the result
// stream stalls, the read overlapping the output; input waits for the last char.
// Reset (rst_ni, async, low): length, discard, error flag and output valid cleared;
// capacity back to 64; the line store itself is not cleared.
module text_line_framer #(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tlf_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
  input  logic [tlf_pkg::OP_W-1:0]          s_axis_tuser,   // [1:0] op
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tlf_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // [7:0] char_out, [8] had_error
  output logic [tlf_pkg::KIND_W-1:0]        m_axis_tuser,   // [1:0] result_kind
  output logic                              m_axis_tlast,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tlf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tlf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import tlf_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX - 1);

  // FSM: IDLE takes items, LOAD streams the stored line out of the memory
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic             state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             disc_q, disc_d;
  logic             err_q, err_d;
  logic [LEN_W-1:0] idx_q, idx_d;        // char being sent from rdata
  logic [LEN_W-1:0] last_idx_q, last_idx_d;

  logic [CAP_W-1:0] cap;

  // memory ports
  logic              mem_we;
  logic [LEN_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [LEN_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [BYTE_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              had_q, had_d;

  logic slot_free;
  logic in_fire;
  logic too_long;

  tlf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // Writes happen only for stored bytes in IDLE; reads start with the LF, which
  // writes nothing, and go on in LOAD, so no entry is written and read in one cycle.
  tlf_line_mem #(
    .DEPTH (LINE_MAX)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign too_long      = (CAP_W'(len_q) >= cap);
  assign mem_waddr     = len_q;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    disc_d     = disc_q;
    err_d      = err_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    kind_d     = kind_q;
    char_d     = char_q;
    last_d     = last_q;
    had_d      = had_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            OP_BYTE: begin
              if (s_axis_tdata == CH_CR) begin
                // carriage return: ignored
              end else if (s_axis_tdata == CH_LF) begin
                len_d = '0;
                if (disc_q) begin
                  disc_d = 1'b0;
                end else if (too_long) begin
                  err_d = 1'b1;
                end else if (len_q == '0) begin
                  out_load = 1'b1;
                  kind_d   = KIND_EMPTY;
                  char_d   = '0;
                  last_d   = 1'b1;
                  had_d    = 1'b0;
                end else begin
                  // start draining: fetch entry 0 now
                  mem_re     = 1'b1;
                  mem_raddr  = '0;
                  idx_d      = '0;
                  last_idx_d = len_q - LEN_W'(1);
                  state_d    = ST_LOAD;
                end
              end else if (!disc_q) begin
                if (len_q != LEN_FULL) begin
                  mem_we = 1'b1;
                  len_d  = len_q + LEN_W'(1);
                end else begin
                  // overlong line
                  err_d  = 1'b1;
                  len_d  = '0;
                  disc_d = 1'b1;
                end
              end
            end
            OP_TAKE_ERR: begin
              out_load = 1'b1;
              kind_d   = KIND_ERROR;
              char_d   = '0;
              last_d   = 1'b1;
              had_d    = err_q;
              err_d    = 1'b0;
              if (err_q) begin
                len_d  = '0;
                disc_d = 1'b1;
              end
            end
            OP_OVERRUN: begin
              err_d = 1'b1;
            end
            default: begin
              // unused op: no effect
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_load = 1'b1;
          kind_d   = KIND_CHAR;
          char_d   = mem_rdata;
          last_d   = (idx_q == last_idx_q);
          had_d    = 1'b0;
          if (idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            // prefetch next char while this one goes out
            mem_re    = 1'b1;
            mem_raddr = idx_q + LEN_W'(1);
            idx_d     = idx_q + LEN_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      disc_q      <= 1'b0;
      err_q       <= 1'b0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      disc_q      <= disc_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only with a new transfer
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= kind_d;
      char_q <= char_d;
      last_q <= last_d;
      had_q  <= had_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-BYTE_W-1){1'b0}}, had_q, char_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

// ----- hdl/tlf_checker.sv -----
// tlf_checker: port-level checks on the text line framer result stream.
// Depends on tlf_pkg; bound to text_line_framer at the end of this file.
module tlf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tlf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic [tlf_pkg::KIND_W-1:0]    m_axis_tuser,
  input  logic                          m_axis_tlast
);
  import tlf_pkg::*;

  // No result shows in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Empty line and error report are single results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_CHAR |-> m_axis_tlast)
    else $error("non-char result without tlast");

  // char_out is zero outside character results
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_CHAR |-> m_axis_tdata[BYTE_W-1:0] == '0)
    else $error("char_out nonzero on non-char result");

  // had_error only on error reports
  a_had_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> !m_axis_tdata[BYTE_W])
    else $error("had_error set outside error report");

endmodule

bind text_line_framer tlf_checker u_tlf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_text_line_framer.sv -----
// tb_text_line_framer: self-checking testbench for the text line framer.
// Needs tlf_pkg and text_line_framer; drives both streams and the APB port and
// checks every result transfer against an in-bench line assembly predictor.
`timescale 1ns / 1ps

module tb_text_line_framer;
  import tlf_pkg::*;

  localparam int unsigned LINE_MAX     = 64;
  localparam int unsigned DRAIN_CYCLES = 80;    // covers the longest line drain
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no transfer at all
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 24;
  localparam logic [OP_W-1:0]       OP_UNUSED = 2'd3;  // not decoded, must be ignored
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR  = {REG_LINE_CAPACITY, 2'b00};

  // One result transfer as the predictor sees it
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
    logic       had;
  } line_result_t;

  // Directed stimulus row: either a capacity write (cfg) or one input transfer.
  // When typed is set the expected result is the one written in the row.
  typedef struct packed {
    bit              cfg;
    logic [OP_W-1:0] op;
    logic [7:0]      data;
    bit              typed;
    kind_e           kind;
    logic [7:0]      ch;
    bit              had;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // [7:0] rx_byte
  logic [OP_W-1:0]       s_axis_tuser  = '0;   // [1:0] op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;         // [7:0] char_out, [8] had_error
  logic [KIND_W-1:0]     m_axis_tuser;         // [1:0] result_kind
  logic                  m_axis_tlast;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  text_line_framer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the line store, length, discard and
  // error flags, plus the capacity register as last written.
  // ---------------------------------------------------------------------------
  logic [7:0]   line_mem [LINE_MAX];
  int unsigned  line_len     = 0;
  bit           discard_mode = 1'b0;
  bit           err_flag     = 1'b0;
  logic [CAP_W-1:0] capacity = CAP_RESET;

  line_result_t pending_results [$];   // expected results, oldest first

  int unsigned  send_idle_pct  = 0;    // chance per cycle that the sender holds off
  int unsigned  recv_stall_pct = 0;    // chance per cycle that tready is low
  int unsigned  mismatches     = 0;
  int unsigned  items_sent     = 0;    // transfers that the block acts on
  int unsigned  phase_items    = 0;
  int unsigned  results_seen   = 0;
  int unsigned  lines_seen     = 0;
  int unsigned  cap_writes     = 0;

  line_result_t got_res;
  line_result_t want_res;

  // Clock: 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Line assembly predictor: advances the private state by one accepted input
  // transfer and queues whatever results that transfer causes.
  task automatic assemble_step(input logic [OP_W-1:0] op, input logic [7:0] b);
    int unsigned n;
    case (op)
      OP_BYTE: begin
        if (b == CH_CR) begin
          // carriage return never reaches the store
        end else if (b == CH_LF) begin
          if (discard_mode) begin
            // end of a discarded line: silently back to normal
            discard_mode = 1'b0;
            line_len     = 0;
          end else if (line_len >= capacity) begin
            // too long for the consumer (zero capacity drops even empty lines)
            err_flag = 1'b1;
            line_len = 0;
          end else begin
            n        = line_len;
            line_len = 0;
            if (n == 0) begin
              pending_results.push_back('{KIND_EMPTY, 8'h00, 1'b1, 1'b0});
            end else begin
              for (int unsigned i = 0; i < n; i++)
                pending_results.push_back('{KIND_CHAR, line_mem[i], i + 1 == n, 1'b0});
            end
          end
        end else if (!discard_mode) begin
          if (line_len < LINE_MAX - 1) begin
            line_mem[line_len] = b;
            line_len++;
          end else begin
            // store already full: flag it and drop the rest of the line
            err_flag     = 1'b1;
            line_len     = 0;
            discard_mode = 1'b1;
          end
        end
      end
      OP_TAKE_ERR: begin
        pending_results.push_back('{KIND_ERROR, 8'h00, 1'b1, err_flag});
        if (err_flag) begin
          line_len     = 0;
          discard_mode = 1'b1;
        end
        err_flag = 1'b0;
      end
      OP_OVERRUN: err_flag = 1'b1;
      default: ;  // unused op: no effect
    endcase
  endtask

  // Offer one input transfer; random hold-off cycles come first. The predictor
  // runs at the edge where the transfer happens. A typed row replaces the
  // predicted result with the one written in the table.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] data,
                           input bit typed, input line_result_t typed_res);
    int unsigned depth;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) >= send_idle_pct) break;
      s_axis_tvalid <= 1'b0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    depth = pending_results.size();
    assemble_step(op, data);
    if (typed) begin
      while (pending_results.size() > depth) void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end
    if (!(op == OP_UNUSED || (op == OP_BYTE && data == CH_CR))) begin
      items_sent++;
      phase_items++;
    end
  endtask

  // One text line of len stored characters (CRs may be sprinkled in), then LF
  task automatic send_line(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 6) send_item(OP_BYTE, CH_CR, 1'b0, '0);
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF || b == CH_CR) b = b ^ 8'h40;
      send_item(OP_BYTE, b, 1'b0, '0);
    end
    if ($urandom_range(0, 1) == 1) send_item(OP_BYTE, CH_CR, 1'b0, '0);
    send_item(OP_BYTE, CH_LF, 1'b0, '0);
  endtask

  // Wait until the block is idle: nothing offered, nothing expected, and a
  // line drain that produced no result has had time to finish.
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of line_capacity followed by a read-back
  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DATA_W'(cap);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    capacity = cap;
    cap_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(cap))
      note_mismatch($sformatf("capacity read-back expected %h got %h",
                              APB_DATA_W'(cap), prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result sink: tready is redrawn every falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result checker: each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got_res = '{kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[8]};
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind=%0d char=%h last=%b had=%b",
                                got_res.kind, got_res.ch, got_res.last, got_res.had));
      end else begin
        want_res = pending_results.pop_front();
        if (want_res.kind != KIND_ERROR && want_res.last) lines_seen++;
        if (got_res !== want_res || m_axis_tdata[M_TDATA_W-1:9] !== '0)
          note_mismatch($sformatf(
            "exp kind=%0d char=%h last=%b had=%b / got kind=%0d char=%h last=%b had=%b fill=%h",
            want_res.kind, want_res.ch, want_res.last, want_res.had,
            got_res.kind, got_res.ch, got_res.last, got_res.had,
            m_axis_tdata[M_TDATA_W-1:9]));
      end
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t         directed_rows [$];
    int unsigned  phase_cap [PHASES];
    int unsigned  r;
    int           len;

    // Directed table. Typed rows carry results obvious from the spec alone.
    //                      cfg  op           data    typed kind        ch     had
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b1, KIND_EMPTY, 8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_CR, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h00, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'hFF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_CR, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    // overrun, then take-error reports it and throws away the next line
    directed_rows.push_back('{1'b0, OP_OVERRUN,  8'h00, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b1});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h41, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_UNUSED,   8'hFF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h7F, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    // capacity 1: empty line passes, one char is dropped with error
    directed_rows.push_back('{1'b1, OP_BYTE,     8'd1,  1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b1, KIND_EMPTY, 8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h55, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b1});
    // zero capacity: first LF closes the discarded line, then even an empty
    // line is too long
    directed_rows.push_back('{1'b1, OP_BYTE,     8'd0,  1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b1});
    // capacity far above the store: nothing dropped for capacity
    directed_rows.push_back('{1'b1, OP_BYTE,     8'd127, 1'b0, KIND_CHAR, 8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h80, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     8'h01, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_BYTE,     CH_LF, 1'b0, KIND_CHAR,  8'h00, 1'b0});
    directed_rows.push_back('{1'b0, OP_TAKE_ERR, 8'h00, 1'b1, KIND_ERROR, 8'h00, 1'b0});

    // capacity per random phase: reset value, extremes, edges around the store
    phase_cap = '{64, 127, 1, 0, 63, $urandom_range(0, 127), 65, $urandom_range(2, 62)};

    // reset held low from the start, released once
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part with light idling on both sides
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        settle_block();
        program_capacity(directed_rows[i].data[CAP_W-1:0]);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                  '{directed_rows[i].kind, directed_rows[i].ch, 1'b1, directed_rows[i].had});
      end
    end

    // random phases: idling mode cycles none / sender 50 / receiver 50 / both 12
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle_block();
      program_capacity(CAP_W'(phase_cap[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // every other phase opens with one line at the store boundary: 62..65 chars
      if (p % 2 == 0) send_line(62 + p / 2);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_line($urandom_range(0, 6));
        end else if (r < 72) begin
          // around the configured capacity
          len = int'(capacity) - 1 + int'($urandom_range(0, 2));
          if (len < 0) len = 0;
          if (len > 66) len = 66;
          send_line(len);
        end else if (r < 75) begin
          send_line($urandom_range(60, 66));
        end else if (r < 84) begin
          send_item(OP_TAKE_ERR, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (r < 88) begin
          send_item(OP_OVERRUN, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          // noise: any op with any byte, bare line feeds included
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end

    settle_block();
    $display("summary: %0d input transfers, %0d capacity writes, %0d phases of idling",
             items_sent, cap_writes, PHASES);
    $display("summary: %0d results checked, %0d lines out, %0d mismatches",
             results_seen, lines_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
